/* rtl/mddw_pkg.sv */
`timescale 1ns / 1ps
// Package for the multi-device deadline watchdog.
// Holds operation codes, register map, configuration and item types; no dependencies.
package mddw_pkg;

    localparam int DEADLINE_W  = 16;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int MASK_W      = 4;
    localparam int IDX_W       = 3;
    localparam int MAX_DEVICES = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [DEADLINE_W-1:0] DEFAULT_DEADLINE_RST = 16'd1000;
    localparam logic [DEADLINE_W-1:0] MAX_DEADLINE_RST     = 16'd5000;

    typedef enum logic [1:0] {
        OP_ARM  = 2'd0,
        OP_FEED = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [0:0] {
        REG_DEFAULT_DEADLINE = 1'b0,
        REG_MAX_DEADLINE     = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [DEADLINE_W-1:0] default_deadline;
        logic [DEADLINE_W-1:0] max_deadline;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [IDX_W-1:0]      device_index;
        logic [DEADLINE_W-1:0] requested_deadline;
        logic [TIME_W-1:0]     timestamp_ms;
        logic                  link_up;
        logic [MASK_W-1:0]     present_mask;
        logic [MASK_W-1:0]     running_mask;
    } item_t;

endpackage

/* rtl/mddw_cfg.sv */
`timescale 1ns / 1ps
// APB register block for the deadline watchdog: default and maximum deadlines.
// Depends on mddw_pkg.
module mddw_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mddw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mddw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mddw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output mddw_pkg::cfg_t                    cfg
);
    import mddw_pkg::*;

    logic [DEADLINE_W-1:0] default_deadline_reg;
    logic [DEADLINE_W-1:0] max_deadline_reg;
    logic                  wr_en;
    reg_idx_t              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_deadline_reg <= DEFAULT_DEADLINE_RST;
            max_deadline_reg     <= MAX_DEADLINE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_DEFAULT_DEADLINE: default_deadline_reg <= pwdata[DEADLINE_W-1:0];
                REG_MAX_DEADLINE:     max_deadline_reg     <= pwdata[DEADLINE_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_DEFAULT_DEADLINE:
                prdata = {{(APB_DATA_W-DEADLINE_W){1'b0}}, default_deadline_reg};
            REG_MAX_DEADLINE:
                prdata = {{(APB_DATA_W-DEADLINE_W){1'b0}}, max_deadline_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.default_deadline = default_deadline_reg;
    assign cfg.max_deadline     = max_deadline_reg;

endmodule

/* rtl/mddw_core.sv */
`timescale 1ns / 1ps
// Watchdog state, single-pass arm/feed/tick evaluation and the result register.
// Depends on mddw_pkg.
module mddw_core #(
    parameter int NUM_DEVICES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mddw_pkg::cfg_t                 cfg,
    input  logic                           item_valid,
    input  mddw_pkg::item_t                item,
    output logic                           advance,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           tripped,
    output logic [mddw_pkg::MASK_W-1:0]    halt_mask,
    output logic [mddw_pkg::MASK_W-1:0]    armed_mask,
    output logic [mddw_pkg::COUNT_W-1:0]   trip_count
);
    import mddw_pkg::*;

    logic [DEADLINE_W-1:0] deadline_reg [NUM_DEVICES];
    logic [DEADLINE_W-1:0] deadline_next [NUM_DEVICES];
    logic [TIME_W-1:0]     last_fed_reg;
    logic [TIME_W-1:0]     last_fed_next;
    logic [COUNT_W-1:0]    trip_counter_reg;
    logic [COUNT_W-1:0]    trip_counter_next;

    logic                  rsp_valid_reg;
    logic                  tripped_reg;
    logic [MASK_W-1:0]     halt_mask_reg;
    logic [MASK_W-1:0]     armed_mask_reg;

    logic                  load;
    logic                  arm_in_range;
    logic [DEADLINE_W-1:0] arm_deadline;
    logic [TIME_W-1:0]     elapsed;
    logic [DEADLINE_W-1:0] best;
    logic [NUM_DEVICES-1:0] keep;
    logic [NUM_DEVICES-1:0] armed_after;
    logic [NUM_DEVICES-1:0] present_ext;
    logic [NUM_DEVICES-1:0] running_ext;
    logic [MAX_DEVICES-1:0] halt_wide;
    logic [MAX_DEVICES-1:0] armed_wide;
    logic                  any_live;
    logic                  trip;
    op_t                   op;

    assign advance = !rsp_valid_reg || !rsp_stall;
    assign load    = item_valid && advance;
    assign op      = op_t'(item.op);

    for (genvar i = 0; i < NUM_DEVICES; i++)
    begin : g_dev
        if (i < MASK_W)
        begin : g_low
            assign present_ext[i] = item.present_mask[i];
            assign running_ext[i] = item.running_mask[i];
        end
        else
        begin : g_high
            assign present_ext[i] = 1'b0;
            assign running_ext[i] = 1'b0;
        end
        assign keep[i]        = (deadline_reg[i] != '0) && present_ext[i] && running_ext[i];
        assign armed_after[i] = (deadline_next[i] != '0);
    end

    for (genvar i = 0; i < MAX_DEVICES; i++)
    begin : g_wide
        if (i < NUM_DEVICES)
        begin : g_used
            assign halt_wide[i]  = trip && keep[i];
            assign armed_wide[i] = armed_after[i];
        end
        else
        begin : g_unused
            assign halt_wide[i]  = 1'b0;
            assign armed_wide[i] = 1'b0;
        end
    end

    assign arm_in_range = {1'b0, item.device_index} < (IDX_W+1)'(NUM_DEVICES);
    assign elapsed      = item.timestamp_ms - last_fed_reg;
    assign any_live     = |keep;

    always_comb
    begin
        if (item.requested_deadline == '0)
            arm_deadline = cfg.default_deadline;
        else if (item.requested_deadline > cfg.max_deadline)
            arm_deadline = cfg.max_deadline;
        else
            arm_deadline = item.requested_deadline;
    end

    always_comb
    begin
        best = cfg.max_deadline;
        for (int i = 0; i < NUM_DEVICES; i++)
        begin
            if (keep[i] && (deadline_reg[i] < best))
                best = deadline_reg[i];
        end
    end

    assign trip = (op == OP_TICK) && any_live &&
                  (!item.link_up || (elapsed > {{(TIME_W-DEADLINE_W){1'b0}}, best}));

    always_comb
    begin
        last_fed_next     = last_fed_reg;
        trip_counter_next = trip_counter_reg;
        for (int i = 0; i < NUM_DEVICES; i++)
            deadline_next[i] = deadline_reg[i];
        case (op)
            OP_ARM:
            begin
                if (arm_in_range)
                begin
                    for (int i = 0; i < NUM_DEVICES; i++)
                    begin
                        if ({1'b0, item.device_index} == (IDX_W+1)'(i))
                            deadline_next[i] = arm_deadline;
                    end
                    last_fed_next = item.timestamp_ms;
                end
            end
            OP_FEED:
                last_fed_next = item.timestamp_ms;
            OP_TICK:
            begin
                for (int i = 0; i < NUM_DEVICES; i++)
                begin
                    if (trip || !keep[i])
                        deadline_next[i] = '0;
                end
                if (trip)
                    trip_counter_next = trip_counter_reg + COUNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DEVICES; i++)
                deadline_reg[i] <= '0;
            last_fed_reg     <= '0;
            trip_counter_reg <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                for (int i = 0; i < NUM_DEVICES; i++)
                    deadline_reg[i] <= deadline_next[i];
                last_fed_reg     <= last_fed_next;
                trip_counter_reg <= trip_counter_next;
            end
            if (advance)
                rsp_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tripped_reg    <= trip;
            halt_mask_reg  <= halt_wide[MASK_W-1:0];
            armed_mask_reg <= armed_wide[MASK_W-1:0];
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign tripped    = tripped_reg;
    assign halt_mask  = halt_mask_reg;
    assign armed_mask = armed_mask_reg;
    assign trip_count = trip_counter_reg;

    a_trip_counts: assert property (@(posedge clk) disable iff (!rst_n)
        load && trip |=> trip_counter_reg == $past(trip_counter_reg) + COUNT_W'(1))
        else $error("trip counter did not advance on a trip");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && trip) |=> $stable(trip_counter_reg))
        else $error("trip counter changed without a trip");

    a_trip_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        load && trip |=> armed_mask_reg == '0)
        else $error("devices still armed after a trip");

    a_halt_only_on_trip: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !tripped_reg |-> halt_mask_reg == '0)
        else $error("halt mask set without a trip");

endmodule

/* rtl/multi_device_deadline_watchdog_top.sv */
`timescale 1ns / 1ps
// Top level of the multi-device deadline watchdog: command register and handshake.
// Depends on mddw_pkg, mddw_cfg and mddw_core.
//
// The watchdog takes one arm, feed or tick transaction per clock cycle while cmd_stall
// is low and returns exactly one result for each: the command register feeds the
// evaluation logic, which loads the result register whenever the result side is not
// stalled; the deadline store, last-fed time and trip counter are updated at that same
// edge, so the next transaction always sees the state that this one left. A stall on
// the result side backs up through the command register into cmd_stall. Registers are
// written over APB and should only be changed while no transaction is outstanding.
module multi_device_deadline_watchdog_top #(
    parameter int NUM_DEVICES = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mddw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mddw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mddw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  logic [1:0]                           op,
    input  logic [mddw_pkg::IDX_W-1:0]           device_index,
    input  logic [mddw_pkg::DEADLINE_W-1:0]      requested_deadline,
    input  logic [mddw_pkg::TIME_W-1:0]          timestamp_ms,
    input  logic                                 link_up,
    input  logic [mddw_pkg::MASK_W-1:0]          present_mask,
    input  logic [mddw_pkg::MASK_W-1:0]          running_mask,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic                                 tripped,
    output logic [mddw_pkg::MASK_W-1:0]          halt_mask,
    output logic [mddw_pkg::MASK_W-1:0]          armed_mask,
    output logic [mddw_pkg::COUNT_W-1:0]         trip_count
);
    import mddw_pkg::*;

    cfg_t  cfg;
    item_t item_reg;
    logic  item_valid_reg;
    logic  advance;
    logic  cmd_take;

    assign cmd_stall = item_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!cmd_stall)
            item_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            item_reg.op                 <= op;
            item_reg.device_index       <= device_index;
            item_reg.requested_deadline <= requested_deadline;
            item_reg.timestamp_ms       <= timestamp_ms;
            item_reg.link_up            <= link_up;
            item_reg.present_mask       <= present_mask;
            item_reg.running_mask       <= running_mask;
        end
    end

    mddw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mddw_core #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .advance    (advance),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .tripped    (tripped),
        .halt_mask  (halt_mask),
        .armed_mask (armed_mask),
        .trip_count (trip_count)
    );

endmodule
